// ===== rtl/core/bffa_pkg.sv =====
// Shared types and codes for the bitmap first-fit allocator.
package bffa_pkg;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_NOT_ALLOC  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [15:0] alloc_size;
        logic [10:0] free_offset;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [10:0] block_offset;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    size_step;
        logic    fit_init;
        logic    fit_step;
        logic    slot_init;
        logic    slot_step;
        logic    mark_alloc;
        logic    mark_free;
        logic    mark_step;
        logic    mul_lo;
        logic    res_load;
        t_status res_status;
    } t_cmd;

    // Conditions reported back by the datapath.
    typedef struct packed {
        logic size_more;
        logic cnt_over;
        logic fit_more;
        logic fit_ok;
        logic slot_more;
        logic slot_full;
        logic mark_more;
        logic hit;
        logic last_entry;
        logic res_free;
    } t_sts;

endpackage

// ===== rtl/core/bffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bffa_datapath.sv =====
// Allocator datapath: bucket map, entry table, scan counters and result register.
module bffa_datapath #(
    parameter int NUM_BUCKETS   = 32,
    parameter int BUCKET_BYTES  = 64,
    parameter int TABLE_ENTRIES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bffa_pkg::t_req i_req,
    input  bffa_pkg::t_cmd i_cmd,
    output bffa_pkg::t_sts o_sts,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    output bffa_pkg::t_rsp o_rsp
);
    import bffa_pkg::*;

    localparam int SW    = $clog2(NUM_BUCKETS);
    localparam int LW    = $clog2(NUM_BUCKETS + 1);
    localparam int CW    = $clog2(NUM_BUCKETS + 2);
    localparam int IW    = $clog2(TABLE_ENTRIES + 1);
    localparam int TW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BBW   = $clog2(BUCKET_BYTES + 1);
    localparam int MW    = ((LW + BBW + 1) > 12) ? (LW + BBW + 1) : 12;
    localparam int AW    = $clog2((NUM_BUCKETS + 1) * BUCKET_BYTES + 1);
    localparam int ACC_W = (AW > 16) ? AW : 17;

    logic              r_kind;
    logic [15:0]       r_size;
    logic [10:0]       r_offset;
    logic [ACC_W-1:0]  r_acc;
    logic [CW-1:0]     r_cnt;
    logic [LW-1:0]     r_b;
    logic [LW-1:0]     r_run;
    logic [LW-1:0]     r_begin;
    logic [IW-1:0]     r_idx;
    logic [SW-1:0]     r_cursor;
    logic [LW-1:0]     r_rem;
    logic [NUM_BUCKETS-1:0]   r_taken;
    logic [TABLE_ENTRIES-1:0] r_active;
    logic [MW-1:0]     r_lo;
    logic [10:0]       r_offs;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [SW+LW-1:0]  ram_wdata;
    logic [SW+LW-1:0]  ram_rdata;
    logic [SW-1:0]     rd_start;
    logic [LW-1:0]     rd_len;
    logic [MW-1:0]     begin_bytes;
    logic [MW-1:0]     start_bytes;
    logic [MW-1:0]     off_ext;

    assign ram_wdata = {r_begin[SW-1:0], r_cnt[LW-1:0]};
    assign rd_start  = ram_rdata[SW+LW-1:LW];
    assign rd_len    = ram_rdata[LW-1:0];

    bffa_ram #(
        .WIDTH (SW + LW),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mark_alloc),
        .i_waddr (r_idx[TW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[TW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign begin_bytes = MW'(r_begin) * MW'(BUCKET_BYTES);
    assign start_bytes = MW'(rd_start) * MW'(BUCKET_BYTES);
    assign off_ext     = MW'(r_offset);

    always_comb begin
        o_sts.size_more  = (r_acc < ACC_W'(r_size)) && (r_cnt <= CW'(NUM_BUCKETS));
        o_sts.cnt_over   = r_cnt > CW'(NUM_BUCKETS);
        o_sts.fit_more   = (r_b < LW'(NUM_BUCKETS)) && (CW'(r_run) < r_cnt);
        o_sts.fit_ok     = CW'(r_run) == r_cnt;
        o_sts.slot_more  = (r_idx < IW'(TABLE_ENTRIES)) && r_active[r_idx[TW-1:0]];
        o_sts.slot_full  = r_idx == IW'(TABLE_ENTRIES);
        o_sts.mark_more  = r_rem != '0;
        // offset lies inside the entry's first bucket
        o_sts.hit        = r_active[r_idx[TW-1:0]] && (off_ext >= r_lo)
                           && (off_ext < r_lo + MW'(BUCKET_BYTES));
        o_sts.last_entry = r_idx == IW'(TABLE_ENTRIES - 1);
        o_sts.res_free   = !r_out_valid || i_rsp_ready;
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_offs <= begin_bytes[10:0];
        if (i_cmd.load) begin
            r_kind   <= i_req.kind;
            r_size   <= i_req.alloc_size;
            r_offset <= i_req.free_offset;
            r_acc    <= ACC_W'(BUCKET_BYTES);
            r_cnt    <= CW'(1);
        end else if (i_cmd.size_step) begin
            r_acc <= r_acc + ACC_W'(BUCKET_BYTES);
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.fit_init) begin
            r_b     <= '0;
            r_run   <= '0;
            r_begin <= '0;
        end else if (i_cmd.fit_step) begin
            r_b <= r_b + LW'(1);
            if (r_taken[r_b[SW-1:0]]) begin
                r_run   <= '0;
                r_begin <= r_b + LW'(1);
            end else begin
                r_run <= r_run + LW'(1);
            end
        end
        if (i_cmd.load || i_cmd.slot_init) begin
            r_idx <= '0;
        end else if (i_cmd.slot_step) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.mul_lo) begin
            r_lo <= start_bytes;
        end
        if (i_cmd.mark_alloc) begin
            r_cursor <= r_begin[SW-1:0];
            r_rem    <= r_cnt[LW-1:0];
        end else if (i_cmd.mark_free) begin
            r_cursor <= rd_start;
            r_rem    <= rd_len;
        end else if (i_cmd.mark_step) begin
            r_cursor <= r_cursor + SW'(1);
            r_rem    <= r_rem - LW'(1);
        end
        if (i_cmd.res_load) begin
            r_out.status       <= i_cmd.res_status;
            r_out.block_offset <= (i_cmd.res_status == ST_OK && r_kind == KIND_ALLOC)
                                  ? r_offs : 11'd0;
        end
    end

    // Heap state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mark_step) begin
                r_taken[r_cursor] <= (r_kind == KIND_ALLOC);
            end
            if (i_cmd.mark_alloc) begin
                r_active[r_idx[TW-1:0]] <= 1'b1;
            end else if (i_cmd.mark_free) begin
                r_active[r_idx[TW-1:0]] <= 1'b0;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== rtl/core/bffa_ctrl.sv =====
// Allocator controller: sequences size count, fit scan, slot scan, marking and lookup.
module bffa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_kind,
    output logic           o_req_ready,
    input  bffa_pkg::t_sts i_sts,
    output bffa_pkg::t_cmd o_cmd
);
    import bffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE,
        S_FIT,
        S_SLOT,
        S_MARK,
        S_RD,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.res_status = r_status;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_req_kind == KIND_FREE) ? S_RD : S_SIZE;
                end
            end
            S_SIZE: begin
                if (i_sts.size_more) begin
                    o_cmd.size_step = 1'b1;
                end else if (i_sts.cnt_over) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.fit_init = 1'b1;
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (i_sts.fit_more) begin
                    o_cmd.fit_step = 1'b1;
                end else if (!i_sts.fit_ok) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.slot_init = 1'b1;
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                if (i_sts.slot_more) begin
                    o_cmd.slot_step = 1'b1;
                end else if (i_sts.slot_full) begin
                    n_status = ST_TABLE_FULL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.mark_alloc = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_MARK;
                end
            end
            S_MARK: begin
                if (i_sts.mark_more) begin
                    o_cmd.mark_step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            // wait for the entry read
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.mark_free = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_MARK;
                end else if (i_sts.last_entry) begin
                    n_status = ST_NOT_ALLOC;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.slot_step = 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                // hold until the result register can take the item
                if (i_sts.res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

// ===== rtl/core/bitmap_first_fit_allocator_top.sv =====
// Top level of the bitmap first-fit allocator.
// Handles one request at a time and gives one result item per request. An
// allocate counts the size out in buckets, one bucket per cycle, then runs a
// first-fit pass over the bucket bitmap (one bitmap bit per cycle, at most
// NUM_BUCKETS bits), scans the table slots for a free one (one per cycle) and
// then marks the run. A free scans the entry table, with a RAM read, a
// multiply and a compare for each entry, and then clears the run one bucket
// per cycle. The result sits in an output register, so a new request is
// taken while it waits.
module bitmap_first_fit_allocator_top #(
    parameter int NUM_BUCKETS   = 32,
    parameter int BUCKET_BYTES  = 64,
    parameter int TABLE_ENTRIES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  bffa_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output bffa_pkg::t_rsp o_rsp
);
    import bffa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_kind  (i_req.kind),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bffa_datapath #(
        .NUM_BUCKETS   (NUM_BUCKETS),
        .BUCKET_BYTES  (BUCKET_BYTES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== rtl/core/bffa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
module bffa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input bffa_pkg::t_rsp o_rsp
);
    import bffa_pkg::*;

    // A waiting result must hold.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result item changed or dropped while stalled");

    // Failed requests report a zero offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |-> o_rsp.block_offset == 11'd0)
        else $error("non-zero offset on a failed request");

    // One request in work at a time.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in work");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

endmodule

bind bitmap_first_fit_allocator_top bffa_checker u_bffa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
